// File: src/acpu_pkg.sv
// ----------------------------------------------------------------------------
// acpu_pkg - shared types and constants for the adaptive counter progress unit
// Measure layout, transfer payload structs, operation and register codes.
// ----------------------------------------------------------------------------
package acpu_pkg;

   localparam int POSITIONS  = 8;
   localparam int MAX_LEVELS = 15;
   localparam int LVL_W      = 4;
   localparam int OP_W       = 2;
   localparam int CNT_W      = 4;
   localparam int ORDER_W    = 2;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 4;

   // operation codes
   localparam logic [OP_W-1:0] OP_PROGRESS = 2'd0;
   localparam logic [OP_W-1:0] OP_TRUNCATE = 2'd1;
   localparam logic [OP_W-1:0] OP_COMPARE  = 2'd2;

   // compare results
   localparam logic [ORDER_W-1:0] ORDER_LESS    = 2'd0;
   localparam logic [ORDER_W-1:0] ORDER_EQUAL   = 2'd1;
   localparam logic [ORDER_W-1:0] ORDER_GREATER = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_BITS_IN_USE = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT      = 4'd1;

   localparam logic [CNT_W-1:0] BITS_IN_USE_RESET = 4'd8;
   localparam logic [LVL_W-1:0] HEIGHT_RESET      = 4'd15;

   typedef logic [LVL_W-1:0] level_type;
   typedef level_type [POSITIONS-1:0] levels_type;

   typedef struct packed {
      logic [OP_W-1:0]      op;
      level_type            level;
      logic                 a_top;
      logic [POSITIONS-1:0] a_bits;
      levels_type           a_levels;
      logic                 b_top;
      logic [POSITIONS-1:0] b_bits;
      levels_type           b_levels;
   } req_type;

   typedef struct packed {
      logic                 r_top;
      logic [POSITIONS-1:0] r_bits;
      levels_type           r_levels;
      logic [ORDER_W-1:0]   order;
   } rsp_type;

   typedef struct packed {
      logic                 top;
      logic [POSITIONS-1:0] bits;
      levels_type           levels;
   } meas_type;

   // clamped configuration seen by the datapath
   typedef struct packed {
      logic [CNT_W-1:0] used_n;
      level_type        bottom;
   } cfg_type;

   function automatic level_type sat_inc(level_type v);
      level_type r;
      if (v >= level_type'(MAX_LEVELS)) r = level_type'(MAX_LEVELS);
      else r = v + 1'b1;
      return r;
   endfunction

   function automatic level_type sat_dec(level_type v);
      level_type r;
      if (v == '0) r = '0;
      else r = v - 1'b1;
      return r;
   endfunction

endpackage

// File: src/acpu_csr.sv
// ----------------------------------------------------------------------------
// acpu_csr - configuration registers
// Holds bits_in_use and height; presents clamped values to the datapath.
// ----------------------------------------------------------------------------
module acpu_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [acpu_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [acpu_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output acpu_pkg::cfg_type                cfg
);

   logic [acpu_pkg::CNT_W-1:0] bits_in_use_ff, bits_in_use_in;
   acpu_pkg::level_type        height_ff, height_in;

   assign csr_ready = 1'b1;

   always_comb begin
      bits_in_use_in = bits_in_use_ff;
      height_in      = height_ff;
      if (csr_valid) begin
         unique case (csr_index)
            acpu_pkg::CSR_BITS_IN_USE: bits_in_use_in = csr_wdata[acpu_pkg::CNT_W-1:0];
            acpu_pkg::CSR_HEIGHT:      height_in      = csr_wdata[acpu_pkg::LVL_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bits_in_use_ff <= acpu_pkg::BITS_IN_USE_RESET;
         height_ff      <= acpu_pkg::HEIGHT_RESET;
      end else begin
         bits_in_use_ff <= bits_in_use_in;
         height_ff      <= height_in;
      end
   end

   // clamp: count to 1..POSITIONS, bottom level to MAX_LEVELS
   always_comb begin
      if (bits_in_use_ff == '0)
         cfg.used_n = acpu_pkg::CNT_W'(1);
      else if (bits_in_use_ff > acpu_pkg::CNT_W'(acpu_pkg::POSITIONS))
         cfg.used_n = acpu_pkg::CNT_W'(acpu_pkg::POSITIONS);
      else
         cfg.used_n = bits_in_use_ff;
      if (height_ff > acpu_pkg::level_type'(acpu_pkg::MAX_LEVELS))
         cfg.bottom = acpu_pkg::level_type'(acpu_pkg::MAX_LEVELS);
      else
         cfg.bottom = height_ff;
   end

endmodule

// File: src/acpu_update.sv
// ----------------------------------------------------------------------------
// acpu_update - progress and truncate of measure A
// One-pass priority logic over the used positions; masks Top and unused slots.
// ----------------------------------------------------------------------------
module acpu_update (
   input  acpu_pkg::cfg_type              cfg,
   input  logic [acpu_pkg::OP_W-1:0]      op,
   input  acpu_pkg::level_type            level,
   input  logic                           a_top,
   input  logic [acpu_pkg::POSITIONS-1:0] a_bits,
   input  acpu_pkg::levels_type           a_levels,
   output acpu_pkg::meas_type             res
);

   logic [acpu_pkg::POSITIONS-1:0] used, run, start, stop, sel, clr;
   logic [acpu_pkg::POSITIONS-1:0] pb, tb;
   acpu_pkg::levels_type           pl, tl;
   logic                           carry, found, bs, b_s, lv_chg, go_top;
   acpu_pkg::level_type            ds, nd, tnd;

   always_comb begin
      // used slots, and the run of top positions whose level is below `level`
      carry = 1'b1;
      for (int j = acpu_pkg::POSITIONS - 1; j >= 0; j--) begin
         used[j] = acpu_pkg::CNT_W'(j) < cfg.used_n;
         run[j]  = used[j] & carry & (a_levels[j] > level);
         if (used[j]) carry = run[j];
      end
      start[0] = run[0];
      stop[0]  = 1'b1;
      for (int j = 1; j < acpu_pkg::POSITIONS; j++) begin
         start[j] = run[j] & ~run[j-1];
         stop[j]  = ~a_bits[j] | (a_levels[j-1] != a_levels[j]);
      end

      // highest used position where the carry chain stops
      found = 1'b0;
      ds    = '0;
      bs    = 1'b0;
      for (int j = acpu_pkg::POSITIONS - 1; j >= 0; j--) begin
         sel[j] = used[j] & stop[j] & ~found;
         clr[j] = used[j] & ~found & ~sel[j];
         found  = found | sel[j];
         if (sel[j]) begin
            ds = a_levels[j];
            bs = a_bits[j];
         end
      end

      b_s    = 1'b1;
      lv_chg = 1'b0;
      go_top = 1'b0;
      nd     = ds;
      if (!bs) begin
         if (ds == cfg.bottom) begin
            b_s = 1'b1;
         end else begin
            b_s    = 1'b0;
            lv_chg = 1'b1;
            nd     = acpu_pkg::sat_inc(ds);
         end
      end else if (sel[0] && ds == '0) begin
         go_top = 1'b1;
      end else begin
         lv_chg = 1'b1;
         nd     = acpu_pkg::sat_dec(ds);
      end

      // progress
      pb = a_bits;
      pl = a_levels;
      if (|run) begin
         // low part becomes a 10..0 run at this level
         for (int j = 0; j < acpu_pkg::POSITIONS; j++) begin
            if (run[j]) begin
               pb[j] = start[j];
               pl[j] = level;
            end
         end
      end else begin
         for (int j = 0; j < acpu_pkg::POSITIONS; j++) begin
            if (clr[j]) pb[j] = 1'b0;
            if (sel[j]) pb[j] = b_s;
            if (lv_chg && (sel[j] || clr[j])) pl[j] = nd;
         end
      end

      // truncate
      tnd = acpu_pkg::sat_inc(level);
      tb  = a_bits;
      tl  = a_levels;
      for (int j = 0; j < acpu_pkg::POSITIONS; j++) begin
         if (run[j]) begin
            tb[j] = 1'b0;
            tl[j] = tnd;
         end
      end

      res = '0;
      unique case (op)
         acpu_pkg::OP_PROGRESS: begin
            res.top    = a_top | go_top;
            res.bits   = pb;
            res.levels = pl;
         end
         acpu_pkg::OP_TRUNCATE: begin
            res.top    = a_top;
            res.bits   = tb;
            res.levels = tl;
         end
         default: ;
      endcase

      for (int j = 0; j < acpu_pkg::POSITIONS; j++) begin
         if (res.top || !used[j]) begin
            res.bits[j]   = 1'b0;
            res.levels[j] = '0;
         end
      end
   end

endmodule

// File: src/acpu_compare.sv
// ----------------------------------------------------------------------------
// acpu_compare - compares measure A with measure B up to a level
// Lowest deciding position wins; Top is above every finite measure.
// ----------------------------------------------------------------------------
module acpu_compare (
   input  acpu_pkg::cfg_type                cfg,
   input  acpu_pkg::level_type              level,
   input  logic                             a_top,
   input  logic [acpu_pkg::POSITIONS-1:0]   a_bits,
   input  acpu_pkg::levels_type             a_levels,
   input  logic                             b_top,
   input  logic [acpu_pkg::POSITIONS-1:0]   b_bits,
   input  acpu_pkg::levels_type             b_levels,
   output logic [acpu_pkg::ORDER_W-1:0]     order
);

   logic                           done;
   logic [acpu_pkg::ORDER_W-1:0]   pos_order;

   always_comb begin
      done      = 1'b0;
      pos_order = acpu_pkg::ORDER_EQUAL;
      for (int j = 0; j < acpu_pkg::POSITIONS; j++) begin
         if (!done && acpu_pkg::CNT_W'(j) < cfg.used_n) begin
            if (a_levels[j] > level && b_levels[j] > level) begin
               done      = 1'b1;
               pos_order = acpu_pkg::ORDER_EQUAL;
            end else if (a_levels[j] < b_levels[j]) begin
               done      = 1'b1;
               pos_order = a_bits[j] ? acpu_pkg::ORDER_GREATER : acpu_pkg::ORDER_LESS;
            end else if (a_levels[j] > b_levels[j]) begin
               done      = 1'b1;
               pos_order = b_bits[j] ? acpu_pkg::ORDER_LESS : acpu_pkg::ORDER_GREATER;
            end else if (a_bits[j] != b_bits[j]) begin
               done      = 1'b1;
               pos_order = a_bits[j] ? acpu_pkg::ORDER_GREATER : acpu_pkg::ORDER_LESS;
            end
         end
      end

      priority if (a_top && b_top) order = acpu_pkg::ORDER_EQUAL;
      else if (a_top)              order = acpu_pkg::ORDER_GREATER;
      else if (b_top)              order = acpu_pkg::ORDER_LESS;
      else                         order = pos_order;
   end

endmodule

// File: src/adaptive_counter_progress_unit.sv
// ----------------------------------------------------------------------------
// adaptive_counter_progress_unit - adaptive counter arithmetic for progress measures
// A request is taken into the input register, and its result into the result register,
// which drives rsp_valid; one transfer per cycle is sustained while rsp_stall is low, set
// by the single pass of update/compare logic between input and result registers.
// Synchronous reset clears both stage valids; bits_in_use=8, height=15 after reset.
// ----------------------------------------------------------------------------
module adaptive_counter_progress_unit (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             req_valid,
   output logic                             req_stall,
   input  acpu_pkg::req_type                req_payload,
   // response channel
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output acpu_pkg::rsp_type                rsp_payload,
   // configuration writes
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [acpu_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [acpu_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   // Two register stages: an input register holding the accepted request, and
   // a result register feeding the response port. The input register may take
   // a new transfer while a finished result waits in the result register.

   acpu_pkg::cfg_type   cfg;
   acpu_pkg::meas_type  upd;
   logic [acpu_pkg::ORDER_W-1:0] cmp_order;

   logic                in_valid_ff, in_valid_in;
   acpu_pkg::req_type   in_data_ff, in_data_in;
   logic                out_valid_ff, out_valid_in;
   acpu_pkg::rsp_type   out_data_ff, out_data_in;
   acpu_pkg::rsp_type   result;

   logic                advance;   // input stage may move into the result register
   logic                req_take;

   acpu_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // progress / truncate of A
   acpu_update u_update (
      .cfg      (cfg),
      .op       (in_data_ff.op),
      .level    (in_data_ff.level),
      .a_top    (in_data_ff.a_top),
      .a_bits   (in_data_ff.a_bits),
      .a_levels (in_data_ff.a_levels),
      .res      (upd)
   );

   // ordering of A against B
   acpu_compare u_compare (
      .cfg      (cfg),
      .level    (in_data_ff.level),
      .a_top    (in_data_ff.a_top),
      .a_bits   (in_data_ff.a_bits),
      .a_levels (in_data_ff.a_levels),
      .b_top    (in_data_ff.b_top),
      .b_bits   (in_data_ff.b_bits),
      .b_levels (in_data_ff.b_levels),
      .order    (cmp_order)
   );

   // result assembly: order only for compare, measure fields already gated by op
   always_comb begin
      result.r_top    = upd.top;
      result.r_bits   = upd.bits;
      result.r_levels = upd.levels;
      result.order    = (in_data_ff.op == acpu_pkg::OP_COMPARE) ? cmp_order
                                                                : acpu_pkg::ORDER_LESS;
   end

   // handshake: result register frees when empty or when its transfer completes
   assign advance   = ~out_valid_ff | ~rsp_stall;
   assign req_stall = in_valid_ff & ~advance;
   assign req_take  = req_valid & ~req_stall;

   always_comb begin
      in_valid_in  = req_take | (in_valid_ff & ~advance);
      in_data_in   = req_take ? req_payload : in_data_ff;
      out_valid_in = advance ? in_valid_ff : out_valid_ff;
      out_data_in  = (advance && in_valid_ff) ? result : out_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      in_data_ff  <= in_data_in;
      out_data_ff <= out_data_in;
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_data_ff;

endmodule
